[rtl/sha1bsh_pkg.sv]
// Shared constants, state codes and a rotate helper for the SHA-1 byte stream hasher.
package sha1bsh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned BlkBits  = 512;
  localparam int unsigned NumRnds  = 80;
  localparam int unsigned RndW     = 7;
  localparam int unsigned FillW    = 7;
  localparam int unsigned CountW   = 64;
  localparam int unsigned StateW   = 3;

  typedef logic [WordW-1:0] word_t;

  localparam word_t IvH0 = 32'h67452301;
  localparam word_t IvH1 = 32'hEFCDAB89;
  localparam word_t IvH2 = 32'h98BADCFE;
  localparam word_t IvH3 = 32'h10325476;
  localparam word_t IvH4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [FillW-1:0] LenPos   = 7'd56;
  localparam logic [FillW-1:0] LastFill = 7'd63;
  localparam logic [RndW-1:0]  LastRnd  = 7'd79;
  localparam logic [IdxW-1:0]  LastIdx  = 3'd4;

  // sequencer state codes
  localparam logic [StateW-1:0] StIdle  = 3'd0;
  localparam logic [StateW-1:0] StPad   = 3'd1;
  localparam logic [StateW-1:0] StLen   = 3'd2;
  localparam logic [StateW-1:0] StRound = 3'd3;
  localparam logic [StateW-1:0] StAdd   = 3'd4;
  localparam logic [StateW-1:0] StOut   = 3'd5;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WordW - n));
  endfunction

endpackage

[rtl/sha1_byte_stream_hasher_core.sv]
// SHA-1 byte stream hasher: byte collection, padding, shared round unit, digest output.
//
// Input channel (s_axis): one message byte per transfer in tdata[7:0]; tuser[0] says the
// byte is valid, tlast marks the final item of a message (it may carry no byte).
// Output channel (m_axis): after the final item, five transfers carry the digest words
// H0..H4 in tdata, the word index in tuser, and tlast on H4.
// Throughput: one byte per cycle while a block fills; every 64th byte starts the
// compression in the single round unit, followed by the chaining add, and no byte is
// taken until it is done. The round unit does one round per cycle.
// After the final item: the 0x80 marker and zero bytes up to the length position, then the
// eight length bytes, one or two compressions, then the five digest words.
// s_axis_tready_o is low while a block is compressed, padded or the digest is sent.
// If the receiver stalls, the current word holds; the next message waits until H4
// is taken, after which the chaining words return to the standard initial values.
// Reset (rst_ni low, asynchronous) restores the initial values and clears all counts.
module sha1_byte_stream_hasher_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,  // [7:0] data_byte
  input  logic                               s_axis_tuser_i,  // [0] has_byte
  input  logic                               s_axis_tlast_i,  // end_of_message
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sha1bsh_pkg::WordW-1:0]      m_axis_tdata_o,  // [31:0] digest_word
  output logic [sha1bsh_pkg::IdxW-1:0]       m_axis_tuser_o,  // [2:0] word_index
  output logic                               m_axis_tlast_o   // last_word
);
  import sha1bsh_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [CountW-1:0] count_q, count_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [IdxW-1:0]   oidx_q, oidx_d;
  logic              pad_q, pad_d;     // padding in progress
  logic              p80_q, p80_d;     // 0x80 marker already placed
  logic              fin_q, fin_d;     // length placed, next compression is the last
  word_t             h_q [NumWords];
  word_t             h_d [NumWords];
  word_t             a_q, b_q, c_q, d_q, e_q;
  word_t             a_d, b_d, c_d, d_d, e_d;
  logic [BlkBits-1:0] sr_q, sr_d;      // block bytes, then the 16-word schedule window

  logic              in_xfer, out_xfer;
  logic              put_en;
  logic [7:0]        put_byte;
  logic [CountW-1:0] bits_w;
  word_t             w0, w_new, f_w, k_w, t_w;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign bits_w   = {count_q[CountW-4:0], 3'b000};

  // schedule taps: window holds w[t..t+15], w[t] in the top word
  assign w0    = sr_q[BlkBits-1 -: WordW];
  assign w_new = rotl(sr_q[95:64] ^ sr_q[255:224] ^ sr_q[447:416] ^ w0, 1);

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_w = (b_q & c_q) | (~b_q & d_q);
      k_w = K0;
    end else if (rnd_q < 7'd40) begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = K1;
    end else if (rnd_q < 7'd60) begin
      f_w = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_w = K2;
    end else begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = K3;
    end
  end

  assign t_w = rotl(a_q, 5) + f_w + e_q + k_w + w0;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    count_d = count_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    pad_d   = pad_q;
    p80_d   = p80_q;
    fin_d   = fin_q;
    h_d     = h_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    sr_d     = sr_q;
    put_en   = 1'b0;
    put_byte = 8'h00;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          put_en   = s_axis_tuser_i;
          put_byte = s_axis_tdata_i;
          if (s_axis_tuser_i) begin
            count_d = count_q + 64'd1;
          end
          if (s_axis_tlast_i) begin
            pad_d   = 1'b1;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (!p80_q) begin
          put_en   = 1'b1;
          put_byte = PadByte;
          p80_d    = 1'b1;
        end else if (fill_q == LenPos) begin
          state_d = StLen;
        end else begin
          put_en   = 1'b1;
          put_byte = 8'h00;
        end
      end
      StLen: begin
        put_en   = 1'b1;
        put_byte = bits_w[{~fill_q[2:0], 3'b000} +: 8];
        if (fill_q == LastFill) begin
          fin_d = 1'b1;
        end
      end
      StRound: begin
        a_d  = t_w;
        b_d  = a_q;
        c_d  = rotl(b_q, 30);
        d_d  = c_q;
        e_d  = d_q;
        sr_d = {sr_q[BlkBits-WordW-1:0], w_new};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LastRnd) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        if (fin_q) begin
          oidx_d  = '0;
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_xfer) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == LastIdx) begin
            h_d     = '{IvH0, IvH1, IvH2, IvH3, IvH4};
            count_d = '0;
            pad_d   = 1'b0;
            p80_d   = 1'b0;
            fin_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // byte insertion; a full block hands off to the round unit
    if (put_en) begin
      sr_d   = {sr_q[BlkBits-9:0], put_byte};
      fill_d = fill_q + 7'd1;
      if (fill_q == LastFill) begin
        fill_d  = '0;
        rnd_d   = '0;
        a_d = h_q[0]; b_d = h_q[1]; c_d = h_q[2]; d_d = h_q[3]; e_d = h_q[4];
        state_d = StRound;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      pad_q   <= 1'b0;
      p80_q   <= 1'b0;
      fin_q   <= 1'b0;
      h_q     <= '{IvH0, IvH1, IvH2, IvH3, IvH4};
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      pad_q   <= pad_d;
      p80_q   <= p80_d;
      fin_q   <= fin_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    a_q  <= a_d;
    b_q  <= b_d;
    c_q  <= c_d;
    d_q  <= d_d;
    e_q  <= e_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tuser_o  = oidx_q;
  assign m_axis_tlast_o  = (oidx_q == LastIdx);

  always_comb begin
    unique case (oidx_q)
      3'd0:    m_axis_tdata_o = h_q[0];
      3'd1:    m_axis_tdata_o = h_q[1];
      3'd2:    m_axis_tdata_o = h_q[2];
      3'd3:    m_axis_tdata_o = h_q[3];
      3'd4:    m_axis_tdata_o = h_q[4];
      default: m_axis_tdata_o = '0;
    endcase
  end

endmodule

[verif/sha1_byte_stream_hasher_core_tb.sv]
// Self-checking testbench for the SHA-1 byte stream hasher core.
`timescale 1ns / 100ps

module sha1_byte_stream_hasher_core_tb;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned StuckLimit  = 3000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned ItemTarget  = 310;

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;
  localparam logic [159:0] InitChain =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [7:0]  PadMark = 8'h80;

  // well-known digests of "" and "abc"
  localparam logic [159:0] EmptyDigest = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] AbcDigest   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  typedef struct packed {
    logic [7:0]   data;
    logic         has_byte;
    logic         eom;
    logic         typed;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam int unsigned NumRows = 16;
  localparam stim_row_t DirTab [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message right after reset
    '{8'h5A, 1'b0, 1'b0, 1'b0, '0},           // no byte, no end: ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // byte carried on the end item
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b1, 1'b0, '0},           // end without byte, data ignored
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty again after reinit
    '{8'hFF, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h80, 1'b1, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFE, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0}
  };

  localparam int unsigned BlockEdgeLens [3] = '{55, 56, 64};
  localparam int unsigned PadEdgeLens [6]   = '{55, 56, 57, 63, 64, 65};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [sha1bsh_pkg::WordW-1:0] m_axis_tdata_o;
  logic [sha1bsh_pkg::IdxW-1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // hash state mirror
  logic [31:0] chain_h [DigestWords];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] msg_bytes;
  logic [31:0] digest_out [DigestWords];

  digest_beat_t digest_q [$];

  bit          idle_on;
  int unsigned items_sent;
  int unsigned bytes_sent;
  int unsigned msgs_done;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned stuck_cycles;

  sha1_byte_stream_hasher_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void chain_init();
    for (int i = 0; i < DigestWords; i++) begin
      chain_h[i] = InitChain[159-32*i -: 32];
    end
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void buffer_byte(input logic [7:0] v);
    blk_buf[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      sha1_compress();
      blk_fill = 0;
    end
  endfunction

  // Takes one input item; returns 1 when the message closed and digest_out holds its hash.
  function automatic bit hash_absorb(input logic [7:0] d, input bit hb, input bit eom);
    logic [63:0] nbits;
    if (hb) begin
      buffer_byte(d);
      msg_bytes++;
    end
    if (!eom) return 1'b0;
    nbits = msg_bytes << 3;
    buffer_byte(PadMark);
    while (blk_fill != 56) buffer_byte(8'h00);
    for (int i = 0; i < 8; i++) begin
      blk_buf[56+i] = nbits[63-8*i -: 8];
    end
    sha1_compress();
    blk_fill = 0;
    for (int i = 0; i < DigestWords; i++) begin
      digest_out[i] = chain_h[i];
    end
    chain_init();
    msg_bytes = '0;
    return 1'b1;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic send_item(input logic [7:0] d, input bit hb, input bit eom,
                           input bit typed = 1'b0, input logic [159:0] typed_dig = '0);
    int unsigned gap;
    digest_beat_t beat;
    gap = pick_idle();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= hb;
    s_axis_tlast_i  <= eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (hash_absorb(d, hb, eom)) begin
      for (int i = 0; i < DigestWords; i++) begin
        beat = '{typed ? typed_dig[159-32*i -: 32] : digest_out[i],
                 3'(i), i == DigestWords - 1};
        digest_q = {digest_q, beat};
      end
      msgs_done++;
    end
    if (hb || eom) items_sent++;
    if (hb) bytes_sent++;
    @(negedge clk_i);
  endtask

  // Sender holds off until every pending digest word has been taken.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned nbytes);
    bit tail_empty;
    tail_empty = (nbytes == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == nbytes - 1) && !tail_empty);
    end
    if (tail_empty) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver back-pressure.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall == 0) stall = pick_idle();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Output checker and watchdog.
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d words pending",
               StuckLimit, digest_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected digest transfer word=%h idx=%0d last=%b",
                   $realtime, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end
      end else begin
        exp_beat = digest_q.pop_front();
        words_checked++;
        if (m_axis_tdata_o !== exp_beat.word || m_axis_tuser_o !== exp_beat.idx ||
            m_axis_tlast_o !== exp_beat.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: digest mismatch exp word=%h idx=%0d last=%b, got word=%h idx=%0d last=%b",
                     $realtime, exp_beat.word, exp_beat.idx, exp_beat.last,
                     m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned nbytes;
    int unsigned sel;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    idle_on         = 1'b0;
    items_sent      = 0;
    bytes_sent      = 0;
    msgs_done       = 0;
    words_checked   = 0;
    mismatches      = 0;
    stuck_cycles    = 0;
    chain_init();
    for (int i = 0; i < 64; i++) blk_buf[i] = '0;
    blk_fill  = 0;
    msg_bytes = '0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows, back to back with the receiver always ready
    foreach (DirTab[r]) begin
      send_item(DirTab[r].data, DirTab[r].has_byte, DirTab[r].eom,
                DirTab[r].typed, DirTab[r].digest);
    end
    hold_until_drained();

    // random messages; block-edge lengths first, then a mix weighted to short ones
    for (int m = 0; items_sent < ItemTarget || m < 3; m++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (m < 3) begin
        nbytes = BlockEdgeLens[m];
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7)      nbytes = $urandom_range(0, 12);
        else if (sel < 9) nbytes = PadEdgeLens[$urandom_range(0, 5)];
        else              nbytes = $urandom_range(119, 120);
      end
      send_message(nbytes);
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d messages, %0d bytes in %0d input items (empty, one-byte,",
             msgs_done, bytes_sent, items_sent);
    $display("  block-edge and two-block lengths); %0d digest words checked, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
